// ===== design/assert_macros.svh =====
// Assertion macros for the RTL of the masked byte pattern search unit.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition forces a consequence on the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/mbps_pkg.sv =====
// Package for the masked byte pattern search unit: widths, mode codes, beat types.
// No dependencies; imported by the interfaces and every module of the unit.
package mbps_pkg;

   localparam int MAX_PATTERN_DEF = 64;

   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 6;
   localparam int BYTE_W   = 8;
   localparam int LENGTH_W = 7;
   localparam int OFFSET_W = 32;

   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DATA  = 2'd2;

   localparam logic [LENGTH_W-1:0] PATTERN_LENGTH_RESET = 7'd1;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] entry_index;
      logic [BYTE_W-1:0]  byte_value;
      logic               care;
      logic               last;
   } req_payload_type;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] match_offset;
   } rsp_payload_type;

   // Broadcast from the top level to every cell of the chain.
   typedef struct packed {
      logic              advance;
      logic              flush;
      logic [BYTE_W-1:0] data_byte;
   } scan_ctrl_type;

endpackage

// ===== design/mbps_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on mbps_pkg for the payload types.
interface mbps_req_if import mbps_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mbps_rsp_if import mbps_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/mbps_cell.sv =====
// One pattern position: stored byte, care bit and partial-match bit.
// Depends on mbps_pkg; instantiated as a chain by the top level.
module mbps_cell import mbps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_en,
   input  logic [BYTE_W-1:0] load_byte,
   input  logic              load_care,
   input  scan_ctrl_type     scan,
   input  logic              prev_bit,
   output logic              partial_next,
   output logic              partial_q
);

   logic [BYTE_W-1:0] pattern_ff;
   logic              care_ff;
   logic              partial_ff;
   logic              partial_in;
   logic              hit;

   // A wildcard position matches any byte.
   assign hit          = !care_ff || (pattern_ff == scan.data_byte);
   assign partial_in   = prev_bit && hit;
   assign partial_next = partial_in;
   assign partial_q    = partial_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         pattern_ff <= load_byte;
         care_ff    <= load_care;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 1'b0;
      end else if (scan.flush) begin
         partial_ff <= 1'b0;
      end else if (scan.advance) begin
         partial_ff <= partial_in;
      end
   end

endmodule

// ===== design/mbps_rsp_buf.sv =====
// Two-entry response buffer: output register plus skid entry.
// Depends on mbps_pkg for the response payload type.
module mbps_rsp_buf import mbps_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_payload_type push_data,
   output logic            space,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_payload_type out_data
);

   logic            head_valid_ff, head_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type head_ff, head_in;
   rsp_payload_type skid_ff, skid_in;
   logic            pop;

   assign pop       = head_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== design/masked_byte_pattern_search_unit.sv =====
// Channel    | Dir | Beat contents
// req_chan   | in  | mode, entry_index, byte_value, care, last
// rsp_chan   | out | found, match_offset
// csr_*      | in  | pattern_length write (write enable + data, no read-back)
//
// Takes one request beat per cycle while req_chan.ready is high; the response
// goes into the response buffer. Each chain cell compares its byte in the same cycle.
// Reset (synchronous, active high) clears partial matches, scan position, the
// found flag, the response buffer and sets pattern_length to 1; the pattern
// store is not cleared and must be loaded before a scan.
// req_chan.ready drops only while both response buffer entries are occupied.
// Depends on mbps_pkg, mbps_if, mbps_cell, mbps_rsp_buf and assert_macros.svh.
`include "assert_macros.svh"

module masked_byte_pattern_search_unit import mbps_pkg::*; #(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   mbps_req_if.sink            req_chan,
   mbps_rsp_if.source          rsp_chan,
   input  logic                csr_write_enable,
   input  logic [LENGTH_W-1:0] csr_write_data
);

   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic                   req_accept;
   logic                   load_beat;
   scan_ctrl_type          scan;
   logic [MAX_PATTERN-1:0] partial_next;
   logic [MAX_PATTERN-1:0] partial_q;

   logic [LENGTH_W-1:0]    pattern_length_ff;
   logic [OFFSET_W-1:0]    byte_position_ff, byte_position_in;
   logic                   found_ff, found_in;

   logic [OFFSET_W-1:0]    sel_wide;
   logic [IDX_W-1:0]       sel_idx;
   logic                   match_hit;
   logic                   rsp_push;
   rsp_payload_type        rsp_data;
   logic                   buf_space;

   // Handshake and decode of the request beat.
   assign req_chan.ready = buf_space;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign load_beat      = req_accept && (req_chan.payload.mode == MODE_LOAD);

   // Advance the chain on a data byte; drop all scan state on a new scan or
   // after the byte that closes a region.
   assign scan.advance   = req_accept && (req_chan.payload.mode == MODE_DATA);
   assign scan.flush     = req_accept &&
                           ((req_chan.payload.mode == MODE_START) ||
                            ((req_chan.payload.mode == MODE_DATA) &&
                             req_chan.payload.last));
   assign scan.data_byte = req_chan.payload.byte_value;

   // Pattern length register; the user must write it only while the unit is idle, the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= PATTERN_LENGTH_RESET;
      end else if (csr_write_enable) begin
         pattern_length_ff <= csr_write_data;
      end
   end

   // Chain of cells: cell k looks at the old partial bit of cell k-1, so a
   // match grows by one position per data byte. Cell 0 always has a start.
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic prev_bit;
      logic cell_load;

      if (k == 0) begin : g_head
         assign prev_bit = 1'b1;
      end else begin : g_link
         assign prev_bit = partial_q[k-1];
      end

      // Index beyond the chain never matches, so such a load is dropped.
      assign cell_load = load_beat && (int'(req_chan.payload.entry_index) == k);

      mbps_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .load_en      (cell_load),
         .load_byte    (req_chan.payload.byte_value),
         .load_care    (req_chan.payload.care),
         .scan         (scan),
         .prev_bit     (prev_bit),
         .partial_next (partial_next[k]),
         .partial_q    (partial_q[k])
      );
   end

   // Position of the last pattern byte in use: zero length acts as one,
   // anything past the chain acts as the full chain.
   always_comb begin
      if (pattern_length_ff == '0) begin
         sel_wide = '0;
      end else if (32'(pattern_length_ff) > 32'(MAX_PATTERN)) begin
         sel_wide = 32'(MAX_PATTERN - 1);
      end else begin
         sel_wide = 32'(pattern_length_ff) - 32'd1;
      end
   end

   assign sel_idx   = sel_wide[IDX_W-1:0];
   assign match_hit = partial_next[sel_idx];

   // One response per region: the first full match, or not-found on the
   // closing byte when nothing matched.
   assign rsp_push              = scan.advance && !found_ff &&
                                  (match_hit || req_chan.payload.last);
   assign rsp_data.found        = match_hit;
   assign rsp_data.match_offset = match_hit ? (byte_position_ff - sel_wide) : '0;

   always_comb begin
      byte_position_in = byte_position_ff;
      found_in         = found_ff;
      if (scan.flush) begin
         byte_position_in = '0;
         found_in         = 1'b0;
      end else if (scan.advance) begin
         byte_position_in = byte_position_ff + 32'd1;
         found_in         = found_ff || match_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         found_ff         <= 1'b0;
      end else begin
         byte_position_ff <= byte_position_in;
         found_ff         <= found_in;
      end
   end

   mbps_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .space     (buf_space),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_chan.payload)
   );

   // Request side can only stall while a response is on offer.
   `ASSERT_ALWAYS(a_stall_has_rsp, clock, reset, req_chan.ready || rsp_chan.valid, "stall without pending response")
   // A found result mid-region blocks further results for that region.
   `ASSERT_NEXT(a_found_latched, clock, reset, rsp_push && rsp_data.found && !scan.flush, found_ff, "found flag not set after match")
   // Closing a region or starting a scan resets the scan state.
   `ASSERT_NEXT(a_flush_clears, clock, reset, scan.flush, (byte_position_ff == '0) && !found_ff && (partial_q == '0), "scan state not cleared")
   // A pushed response always lands in the buffer on the next edge.
   `ASSERT_NEXT(a_push_lands, clock, reset, rsp_push, rsp_chan.valid, "response lost")

endmodule

// ===== test/tb_masked_byte_pattern_search_unit.sv =====
// Self-checking testbench for masked_byte_pattern_search_unit: directed and random scans,
// predicted in-bench and checked beat by beat on the response channel.
// Depends on mbps_pkg, the mbps_req_if/mbps_rsp_if interfaces and the unit's RTL.
module tb_masked_byte_pattern_search_unit;
   import mbps_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = MAX_PATTERN_DEF;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [BYTE_W-1:0] SIGNATURE_CHAR = 8'h78; // 'x'
   localparam int RANDOM_BEATS = 750;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 600000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [LENGTH_W-1:0] csr_write_data;

   mbps_req_if req_if ();
   mbps_rsp_if rsp_if ();

   masked_byte_pattern_search_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ---------------------------------------------------------------------
   // Search predictor: signature store, partial-match chain, scan position.
   // Starts in the post-reset state; reset is applied only once.
   // ---------------------------------------------------------------------
   logic [BYTE_W-1:0]   sig_byte [DEPTH];
   logic                sig_care [DEPTH];
   logic [DEPTH-1:0]    match_chain = '0;
   logic [OFFSET_W-1:0] scan_pos = '0;
   logic                scan_hit = 1'b0;
   logic [LENGTH_W-1:0] model_len = PATTERN_LENGTH_RESET;

   rsp_payload_type expected_hits [$];
   rsp_payload_type want_result;
   int error_count = 0;
   int beats_sent = 0;
   int cycle_count = 0;
   bit steady_tx = 1'b0;

   // Receiver hold-off handshake: the test bumps hold_requests, the ready
   // process notices and counts out the stall itself.
   int hold_requests = 0;
   int holds_served = 0;
   int rsp_stall_left = 0;
   int rsp_burst_left = 0;
   int ready_pick;

   initial begin
      for (int k = 0; k < DEPTH; k++) begin
         sig_byte[k] = '0;
         sig_care[k] = 1'b0;
      end
   end

   // Register value 0 acts as 1, anything above the store depth as full depth.
   function automatic int unsigned effective_span(input logic [LENGTH_W-1:0] len);
      if (len == 0)
         return 1;
      if (len > DEPTH)
         return DEPTH;
      return int'(len);
   endfunction

   // Append one expected response beat at the tail of the queue.
   function automatic void queue_expect(input rsp_payload_type res);
      expected_hits.insert(expected_hits.size(), res);
   endfunction

   // Apply one accepted request beat and queue the response it should cause.
   function automatic void advance_scan(input req_payload_type beat);
      logic [DEPTH-1:0] hit;
      int unsigned span;
      rsp_payload_type res;
      case (beat.mode)
         MODE_LOAD: begin
            sig_byte[beat.entry_index] = beat.byte_value;
            sig_care[beat.entry_index] = beat.care;
         end
         MODE_START: begin
            match_chain = '0;
            scan_pos = '0;
            scan_hit = 1'b0;
         end
         MODE_DATA: begin
            for (int k = 0; k < DEPTH; k++)
               hit[k] = !sig_care[k] || (sig_byte[k] == beat.byte_value);
            // Position 0 always has a predecessor; the rest shift up the chain.
            match_chain = {match_chain[DEPTH-2:0], 1'b1} & hit;
            span = effective_span(model_len);
            if (!scan_hit && match_chain[span-1]) begin
               res.found = 1'b1;
               res.match_offset = scan_pos - OFFSET_W'(span - 1);
               queue_expect(res);
               scan_hit = 1'b1;
            end else if (beat.last && !scan_hit) begin
               res.found = 1'b0;
               res.match_offset = '0;
               queue_expect(res);
            end
            scan_pos = scan_pos + OFFSET_W'(1);
            if (beat.last) begin
               match_chain = '0;
               scan_pos = '0;
               scan_hit = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   // Watch both input ports and feed the predictor at each accepting edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable === 1'b1)
            model_len = csr_write_data;
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
            advance_scan(req_if.payload);
      end
   end

   // Compare every accepted response beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected response beat found=%0b offset=%0d",
                     $time, rsp_if.payload.found, rsp_if.payload.match_offset);
            error_count++;
         end else begin
            want_result = expected_hits.pop_front();
            if (rsp_if.payload.found !== want_result.found) begin
               $display("%0t: found mismatch expected %0b actual %0b",
                        $time, want_result.found, rsp_if.payload.found);
               error_count++;
            end
            if (rsp_if.payload.match_offset !== want_result.match_offset) begin
               $display("%0t: match_offset mismatch expected %0d actual %0d",
                        $time, want_result.match_offset, rsp_if.payload.match_offset);
               error_count++;
            end
         end
      end
   end

   // Response ready: mostly high, often short stalls, a few long ones, some stall-free
   // bursts, plus the long hold-off the backpressure test asks for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            rsp_stall_left = HOLD_CYCLES;
            rsp_burst_left = 0;
         end
         if (rsp_stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall_left--;
         end else if (rsp_burst_left > 0) begin
            rsp_if.ready <= 1'b1;
            rsp_burst_left--;
         end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 8) begin
               rsp_if.ready <= 1'b1;
               rsp_burst_left = $urandom_range(20, 80);
            end else if (ready_pick < 60) begin
               rsp_if.ready <= 1'b1;
            end else if (ready_pick < 94) begin
               rsp_if.ready <= 1'b0;
               rsp_stall_left = $urandom_range(0, 3);
            end else begin
               rsp_if.ready <= 1'b0;
               rsp_stall_left = $urandom_range(10, 40);
            end
         end
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Beat builders. Fields the mode ignores carry random values so every
   // bit toggles.
   // ---------------------------------------------------------------------
   function automatic req_payload_type data_beat(input logic [BYTE_W-1:0] b,
                                                 input logic last);
      return '{MODE_DATA, INDEX_W'($urandom_range(0, DEPTH - 1)), b,
               1'($urandom_range(0, 1)), last};
   endfunction

   function automatic req_payload_type load_beat(input logic [INDEX_W-1:0] idx,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic care);
      return '{MODE_LOAD, idx, b, care, 1'($urandom_range(0, 1))};
   endfunction

   function automatic req_payload_type start_beat();
      return '{MODE_START, INDEX_W'($urandom_range(0, DEPTH - 1)),
               BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1))};
   endfunction

   function automatic req_payload_type unused_beat();
      return '{MODE_UNUSED, INDEX_W'($urandom_range(0, DEPTH - 1)),
               BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1))};
   endfunction

   // Gap after a beat: mostly none, some short, a few long.
   function automatic int sender_gap();
      int pick;
      if (steady_tx)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      if (pick < 90)
         return $urandom_range(1, 3);
      if (pick < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one beat, hold it until accepted, then optionally drop valid
   // for a gap. Called at a rising edge, returns at a rising edge.
   task automatic send_beat(input req_payload_type beat);
      int gap;
      req_if.valid <= 1'b1;
      req_if.payload <= beat;
      do
         @(posedge clock);
      while (req_if.ready !== 1'b1);
      if (beat.mode != MODE_UNUSED)
         beats_sent++;
      gap = sender_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every queued response, then let the pipe empty.
   task automatic settle_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_hits.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [LENGTH_W-1:0] value);
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Fill the whole signature store so no scan ever reads an unwritten entry.
   task automatic test_store_load();
      for (int i = 0; i < DEPTH; i++)
         send_beat(load_beat(INDEX_W'(i), BYTE_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1))));
      settle_idle();
   endtask

   // One-byte signature at the reset length: a hit, repeats after the hit
   // that stay quiet, a hit on a last byte and a miss on a one-byte region.
   task automatic test_single_byte_scan();
      send_beat(load_beat(INDEX_W'(0), SIGNATURE_CHAR, 1'b1));
      send_beat(start_beat());
      send_beat(data_beat("a", 1'b0));
      send_beat(data_beat(SIGNATURE_CHAR, 1'b0));
      send_beat(data_beat(SIGNATURE_CHAR, 1'b0));
      send_beat(data_beat("q", 1'b1));
      send_beat(data_beat(SIGNATURE_CHAR, 1'b1));
      send_beat(data_beat("b", 1'b1));
      settle_idle();
   endtask

   // Leading wildcard against a zero byte, a region shorter than the
   // signature, a hit on the closing byte and an ignored unused-mode beat.
   task automatic test_wildcard_and_short_region();
      write_length(LENGTH_W'(3));
      send_beat(load_beat(INDEX_W'(0), 8'h00, 1'b0));
      send_beat(load_beat(INDEX_W'(1), SIGNATURE_CHAR, 1'b1));
      send_beat(load_beat(INDEX_W'(2), 8'hFF, 1'b1));
      send_beat(data_beat(SIGNATURE_CHAR, 1'b1));
      send_beat(data_beat(8'h00, 1'b0));
      send_beat(unused_beat());
      send_beat(data_beat(SIGNATURE_CHAR, 1'b0));
      send_beat(data_beat(8'hFF, 1'b1));
      settle_idle();
   endtask

   // Length register at zero, above the store depth and at full depth,
   // with a restart in the middle of a scan.
   task automatic test_length_limits();
      write_length(LENGTH_W'(0));
      send_beat(data_beat(8'hFF, 1'b1));
      settle_idle();
      write_length(7'd127);
      send_beat(data_beat(8'h00, 1'b0));
      send_beat(data_beat(8'h5A, 1'b1));
      settle_idle();
      write_length(LENGTH_W'(DEPTH));
      send_beat(data_beat(8'hA5, 1'b0));
      send_beat(data_beat(8'h3C, 1'b0));
      send_beat(start_beat());
      send_beat(data_beat(8'hC3, 1'b1));
      settle_idle();
   endtask

   // Every beat a one-byte region that hits; hold the response side off so
   // the buffer fills and the request side has to stall.
   task automatic test_response_backpressure();
      write_length(LENGTH_W'(1));
      send_beat(load_beat(INDEX_W'(0), SIGNATURE_CHAR, 1'b0));
      settle_idle();
      steady_tx = 1'b1;
      hold_requests++;
      repeat (24) send_beat(data_beat(BYTE_W'($urandom_range(0, 255)), 1'b1));
      steady_tx = 1'b0;
      settle_idle();
   endtask

   // Random phases: new length, a few entry reloads, then regions that
   // often carry an embedded signature among look-alike bytes. Some phases
   // leave the scan open so the next length takes effect mid-scan.
   task automatic test_random_scans();
      int unsigned start_count, span, reg_len, embed_at, nreg, pick, idx, r, i;
      logic [LENGTH_W-1:0] len_value;
      bit embed, end_open;
      logic [BYTE_W-1:0] b;
      start_count = beats_sent;
      while (beats_sent - start_count < RANDOM_BEATS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            len_value = LENGTH_W'($urandom_range(1, 6));
         else if (pick < 88)
            len_value = LENGTH_W'($urandom_range(7, 20));
         else if (pick < 95)
            len_value = LENGTH_W'($urandom_range(21, DEPTH - 1));
         else begin
            case ($urandom_range(0, 2))
               0: len_value = '0;
               1: len_value = LENGTH_W'(DEPTH);
               default: len_value = LENGTH_W'($urandom_range(DEPTH + 1, 127));
            endcase
         end
         span = effective_span(len_value);
         settle_idle();
         write_length(len_value);

         repeat ($urandom_range(0, 3)) begin
            idx = $urandom_range(0, span - 1);
            send_beat(load_beat(INDEX_W'(idx), BYTE_W'($urandom_range(0, 255)),
                                $urandom_range(0, 99) < 75));
         end
         if ($urandom_range(0, 9) < 7)
            send_beat(start_beat());

         nreg = $urandom_range(1, 4);
         for (r = 0; r < nreg; r++) begin
            if ($urandom_range(0, 4) == 0)
               reg_len = $urandom_range(1, span);
            else
               reg_len = span + $urandom_range(0, 10);
            embed = (reg_len >= span) && ($urandom_range(0, 9) < 6);
            embed_at = embed ? $urandom_range(0, reg_len - span) : 0;
            end_open = (r == nreg - 1) && ($urandom_range(0, 6) == 0);
            for (i = 0; i < reg_len; i++) begin
               // Occasional noise: an ignored beat, a stray reload or a restart.
               if ($urandom_range(0, 99) < 3) begin
                  case ($urandom_range(0, 2))
                     0: send_beat(unused_beat());
                     1: send_beat(load_beat(INDEX_W'($urandom_range(0, DEPTH - 1)),
                                            BYTE_W'($urandom_range(0, 255)),
                                            1'($urandom_range(0, 1))));
                     default: send_beat(start_beat());
                  endcase
               end
               if (embed && i >= embed_at && i < embed_at + span && sig_care[i - embed_at])
                  b = sig_byte[i - embed_at];
               else if ($urandom_range(0, 2) != 0)
                  b = sig_byte[$urandom_range(0, span - 1)];
               else
                  b = BYTE_W'($urandom_range(0, 255));
               send_beat(data_beat(b, (i == reg_len - 1) && !end_open));
            end
         end
      end
      settle_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_store_load();
      test_single_byte_scan();
      test_wildcard_and_short_region();
      test_length_limits();
      test_response_backpressure();
      test_random_scans();

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
